[rtl/core/sphere_box_collision_response_core_macros.svh]
// Assertion macros for the sphere/box collision response core.
// Included by the top level; needs nothing else.
`ifndef SPHERE_BOX_COLLISION_RESPONSE_CORE_MACROS_SVH
`define SPHERE_BOX_COLLISION_RESPONSE_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define SBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define SBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sbc_pkg.sv]
// Shared types, widths and fixed-point helpers for the collision response core.
// No dependencies.
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int S24_W = 24;
    localparam int U23_W = 23;
    localparam int MUL_W = 32;
    localparam int P_W   = 64;
    localparam int BOX_W = 25;
    localparam int D_W   = 26;
    localparam int DD_W  = 52;
    localparam int REM_W = 25;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [S24_W-1:0] t_s24;
    typedef logic        [U23_W-1:0] t_u23;
    typedef logic signed [MUL_W-1:0] t_mop;
    typedef logic signed [P_W-1:0]   t_prod;

    localparam t_prod S24_MAX_P = 64'sd8388607;
    localparam t_prod S24_MIN_P = -64'sd8388608;
    localparam t_prod U23_MAX_P = 64'sd8388607;

    // Clamp to 24-bit signed
    function automatic t_s24 sat24(input t_prod v);
        t_s24 r;
        if (v > S24_MAX_P) begin
            r = S24_MAX_P[S24_W-1:0];
        end else if (v < S24_MIN_P) begin
            r = S24_MIN_P[S24_W-1:0];
        end else begin
            r = v[S24_W-1:0];
        end
        return r;
    endfunction

    // Clamp to 23-bit unsigned
    function automatic t_u23 satu23(input t_prod v);
        t_u23 r;
        if (v > U23_MAX_P) begin
            r = U23_MAX_P[U23_W-1:0];
        end else if (v < 0) begin
            r = '0;
        end else begin
            r = v[U23_W-1:0];
        end
        return r;
    endfunction

    // Arithmetic right shift that rounds toward zero
    function automatic t_prod shr_tz(input t_prod v, input int unsigned sh);
        logic [P_W-1:0] mag;
        mag = v[P_W-1] ? P_W'(-v) : P_W'(v);
        mag = mag >> sh;
        return v[P_W-1] ? -signed'(mag) : signed'(mag);
    endfunction

endpackage

[rtl/core/sbc_item_if.sv]
// Input channel: one load or box transaction with valid/ready.
// Depends on sbc_pkg.
`timescale 1ns / 1ps

interface sbc_item_if;
    import sbc_pkg::*;

    logic valid;
    logic ready;
    logic op;
    t_s24 vec_a_x;
    t_s24 vec_a_y;
    t_s24 vec_a_z;
    t_s24 vec_b_x;
    t_s24 vec_b_y;
    t_s24 vec_b_z;

    modport source (
        output valid, op, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
        input  ready
    );
    modport sink (
        input  valid, op, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
        output ready
    );
endinterface

[rtl/core/sbc_result_if.sv]
// Output channel: ball state after each transaction, valid/ready.
// Depends on sbc_pkg.
`timescale 1ns / 1ps

interface sbc_result_if;
    import sbc_pkg::*;

    logic valid;
    logic ready;
    t_s24 pos_x;
    t_s24 pos_y;
    t_s24 pos_z;
    t_s24 vel_x;
    t_s24 vel_y;
    t_s24 vel_z;
    logic on_ground;
    logic bounced;
    t_u23 peak_impact;
    t_u23 squash_kick;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               on_ground, bounced, peak_impact, squash_kick,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               on_ground, bounced, peak_impact, squash_kick,
        output ready
    );
endinterface

[rtl/core/sbc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_mul (
    input  logic          i_clk,
    input  sbc_pkg::t_mop i_a,
    input  sbc_pkg::t_mop i_b,
    output sbc_pkg::t_prod o_prod
);
    import sbc_pkg::*;

    t_prod r_prod;

    // Register the product for the next step
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule

[rtl/core/sphere_box_collision_response_core.sv]
// Sphere against axis-aligned box collision response, top level.
// Depends on sbc_pkg, sbc_item_if, sbc_result_if, sbc_mul and the macro header.
//
// Usage:
//   i_item carries one transaction: op 0 loads ball position and velocity and
//   clears the contact events, op 1 resolves the ball against one box.
//   o_result returns the ball state after every transaction, one per input.
//   i_cfg_wr_en / i_cfg_wr_data write the ball radius (unsigned Q7.16).
// Sequence:
//   A load passes through the done state to the result register. A box takes a
//   clamp state and four multiplies, and on contact up to 13 more multiplies;
//   with the centre outside the box, contact adds a 26-step square root and
//   three divides of FRAC_BITS+1 steps before them.
//   All products go through one registered 32x32 multiplier; root and divide
//   share one subtractor. One transaction is in work at a time.
// Reset: synchronous, active low; clears ball state, events, radius to 0.5.
// Stall: the result register holds until taken; the next transaction is
//   accepted meanwhile and waits at its end if the register is still full.
`timescale 1ns / 1ps
`include "sphere_box_collision_response_core_macros.svh"

module sphere_box_collision_response_core #(
    parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [sbc_pkg::U23_W-1:0] i_cfg_wr_data,
    sbc_item_if.sink                  i_item,
    sbc_result_if.source              o_result
);
    import sbc_pkg::*;

    // Fixed-point constants
    localparam longint L_ONE   = longint'(1) << FRAC_BITS;
    localparam longint L_RFLR  = ((longint'(62) << FRAC_BITS) + 50) / 100;
    localparam longint L_RWALL = ((longint'(38) << FRAC_BITS) + 50) / 100;
    localparam longint L_NMIN  = ((longint'(55) << FRAC_BITS) + 50) / 100;
    localparam longint L_GRIP  = ((longint'(86) << FRAC_BITS) + 50) / 100;
    localparam longint L_KMAX  = ((longint'(28) << FRAC_BITS) + 5) / 10;
    localparam longint L_KGAIN = ((longint'(34) << FRAC_BITS) + 50) / 100;

    localparam t_mop C_ONE      = MUL_W'(L_ONE);
    localparam t_mop C_E_FLOOR  = MUL_W'(L_ONE + L_RFLR);
    localparam t_mop C_E_WALL   = MUL_W'(L_ONE + L_RWALL);
    localparam t_mop C_NMIN     = MUL_W'(L_NMIN);
    localparam t_mop C_GRIP     = MUL_W'(L_GRIP);
    localparam t_prod C_KMAX    = P_W'(L_KMAX);
    localparam t_mop C_KGAIN    = MUL_W'(L_KGAIN);
    localparam t_s24 RADIUS_RST = 24'sd32768;

    localparam int Q_W  = FRAC_BITS + 1;
    localparam int QC_W = $clog2(FRAC_BITS + 2);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLAMP = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Multiply steps
    localparam logic [4:0] ST_DD_X   = 5'd0;
    localparam logic [4:0] ST_DD_Y   = 5'd1;
    localparam logic [4:0] ST_DD_Z   = 5'd2;
    localparam logic [4:0] ST_RR     = 5'd3;
    localparam logic [4:0] ST_POS_X  = 5'd4;
    localparam logic [4:0] ST_POS_Y  = 5'd5;
    localparam logic [4:0] ST_POS_Z  = 5'd6;
    localparam logic [4:0] ST_VN_X   = 5'd7;
    localparam logic [4:0] ST_VN_Y   = 5'd8;
    localparam logic [4:0] ST_VN_Z   = 5'd9;
    localparam logic [4:0] ST_K      = 5'd10;
    localparam logic [4:0] ST_VEL_X  = 5'd11;
    localparam logic [4:0] ST_VEL_Y  = 5'd12;
    localparam logic [4:0] ST_VEL_Z  = 5'd13;
    localparam logic [4:0] ST_GRIP_X = 5'd14;
    localparam logic [4:0] ST_GRIP_Z = 5'd15;
    localparam logic [4:0] ST_KICK   = 5'd16;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step;
    logic       r_ph;
    t_u23       r_radius;

    // Architectural ball state
    t_s24 r_pos [3];
    t_s24 r_vel [3];
    logic r_ground;
    logic r_bounced;
    t_u23 r_peak;
    t_u23 r_squash;

    // Working registers
    t_s24                    r_c [3];
    t_s24                    r_h [3];
    logic signed [D_W-1:0]   r_d [3];
    logic signed [D_W-1:0]   r_dep [3];
    logic [2:0]              r_pgt;
    logic [DD_W-1:0]         r_dd;
    t_mop                    r_n [3];
    t_mop                    r_pen;
    t_mop                    r_vn;
    t_mop                    r_k;
    logic                    r_floor;
    t_prod                   r_acc;
    logic [DD_W-1:0]         r_sx;
    logic [DD_W-1:0]         r_root;
    logic [DD_W-1:0]         r_bit;
    logic [S24_W-1:0]        r_dl;
    logic [REM_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_quo;
    logic [QC_W-1:0]         r_qcnt;
    logic [1:0]              r_ax;

    // Result register
    logic r_out_valid;
    t_s24 r_o_pos [3];
    t_s24 r_o_vel [3];
    logic r_o_ground;
    logic r_o_bounced;
    t_u23 r_o_peak;
    t_u23 r_o_squash;

    logic item_fire;
    logic out_free;
    t_s24 in_a [3];
    t_s24 in_b [3];

    assign in_a[0] = i_item.vec_a_x;
    assign in_a[1] = i_item.vec_a_y;
    assign in_a[2] = i_item.vec_a_z;
    assign in_b[0] = i_item.vec_b_x;
    assign in_b[1] = i_item.vec_b_y;
    assign in_b[2] = i_item.vec_b_z;

    assign i_item.ready = (r_state == S_IDLE);
    assign item_fire    = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;

    // Clamp the centre to the box on every axis
    logic signed [BOX_W-1:0] cl_lo [3];
    logic signed [BOX_W-1:0] cl_hi [3];
    logic signed [BOX_W-1:0] cl_p  [3];
    logic signed [BOX_W-1:0] cl_q  [3];
    logic signed [D_W-1:0]   cl_d  [3];
    logic signed [D_W-1:0]   cl_da [3];
    logic signed [D_W-1:0]   cl_db [3];
    logic signed [D_W-1:0]   cl_dep [3];
    logic [2:0]              cl_gt;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cl_p[i]  = BOX_W'(r_pos[i]);
            cl_lo[i] = BOX_W'(r_c[i]) - BOX_W'(r_h[i]);
            cl_hi[i] = BOX_W'(r_c[i]) + BOX_W'(r_h[i]);
            if (cl_p[i] < cl_lo[i]) begin
                cl_q[i] = cl_lo[i];
            end else if (cl_p[i] > cl_hi[i]) begin
                cl_q[i] = cl_hi[i];
            end else begin
                cl_q[i] = cl_p[i];
            end
            cl_d[i]   = D_W'(cl_p[i]) - D_W'(cl_q[i]);
            cl_da[i]  = D_W'(cl_p[i]) - D_W'(cl_lo[i]);
            cl_db[i]  = D_W'(cl_hi[i]) - D_W'(cl_p[i]);
            cl_dep[i] = (cl_da[i] < cl_db[i]) ? cl_da[i] : cl_db[i];
            cl_gt[i]  = r_pos[i] > r_c[i];
        end
    end

    // Least-depth axis for a centre inside the box
    logic [1:0]            in_ax;
    logic signed [D_W-1:0] in_m;

    always_comb begin
        if (r_dep[1] <= r_dep[0] && r_dep[1] <= r_dep[2]) begin
            in_ax = 2'd1;
        end else if (r_dep[0] <= r_dep[2]) begin
            in_ax = 2'd0;
        end else begin
            in_ax = 2'd2;
        end
        in_m = (r_dep[0] < r_dep[1]) ? r_dep[0] : r_dep[1];
        if (r_dep[2] < in_m) begin
            in_m = r_dep[2];
        end
    end

    // Select multiplier operands for the current step
    t_mop  mul_a, mul_b;
    t_prod mul_prod;
    t_mop  impact;

    assign impact = -r_vn;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            ST_DD_X:   begin mul_a = MUL_W'(r_d[0]); mul_b = MUL_W'(r_d[0]); end
            ST_DD_Y:   begin mul_a = MUL_W'(r_d[1]); mul_b = MUL_W'(r_d[1]); end
            ST_DD_Z:   begin mul_a = MUL_W'(r_d[2]); mul_b = MUL_W'(r_d[2]); end
            ST_RR: begin
                mul_a = signed'(MUL_W'(r_radius));
                mul_b = signed'(MUL_W'(r_radius));
            end
            ST_POS_X:  begin mul_a = r_n[0]; mul_b = r_pen; end
            ST_POS_Y:  begin mul_a = r_n[1]; mul_b = r_pen; end
            ST_POS_Z:  begin mul_a = r_n[2]; mul_b = r_pen; end
            ST_VN_X:   begin mul_a = MUL_W'(r_vel[0]); mul_b = r_n[0]; end
            ST_VN_Y:   begin mul_a = MUL_W'(r_vel[1]); mul_b = r_n[1]; end
            ST_VN_Z:   begin mul_a = MUL_W'(r_vel[2]); mul_b = r_n[2]; end
            ST_K:      begin mul_a = r_floor ? C_E_FLOOR : C_E_WALL; mul_b = r_vn; end
            ST_VEL_X:  begin mul_a = r_n[0]; mul_b = r_k; end
            ST_VEL_Y:  begin mul_a = r_n[1]; mul_b = r_k; end
            ST_VEL_Z:  begin mul_a = r_n[2]; mul_b = r_k; end
            ST_GRIP_X: begin mul_a = MUL_W'(r_vel[0]); mul_b = C_GRIP; end
            ST_GRIP_Z: begin mul_a = MUL_W'(r_vel[2]); mul_b = C_GRIP; end
            ST_KICK:   begin mul_a = impact; mul_b = C_KGAIN; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    sbc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Shared subtractor for the root and the divides
    logic [DD_W:0] sub_a, sub_b, sub_diff;
    logic          sub_ge;

    always_comb begin
        if (r_state == S_SQRT) begin
            sub_a = {1'b0, r_sx};
            sub_b = {1'b0, r_root + r_bit};
        end else begin
            sub_a = (DD_W + 1)'(r_rem);
            sub_b = (DD_W + 1)'(r_dl);
        end
        sub_diff = sub_a - sub_b;
        sub_ge   = !sub_diff[DD_W];
    end

    // Root step and divide step values
    logic [DD_W-1:0]  sq_root_nx;
    logic [Q_W-1:0]   dv_quo_nx;
    logic [REM_W-1:0] dv_rem_nx;
    logic [REM_W-1:0] dv_mag_nx;
    logic [D_W-1:0]   dv_mag0;
    logic             dv_last;
    t_prod            vn_full;
    t_prod            kick_raw;
    t_prod            kick;
    logic             hard_hit;

    always_comb begin
        sq_root_nx = sub_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
        dv_quo_nx  = {r_quo[Q_W-2:0], sub_ge};
        dv_rem_nx  = sub_ge ? sub_diff[REM_W-1:0] : r_rem;
        dv_last    = (r_qcnt == QC_W'(FRAC_BITS));
        dv_mag0    = r_d[0][D_W-1] ? D_W'(-r_d[0]) : D_W'(r_d[0]);
        case (r_ax)
            2'd0:    dv_mag_nx = r_d[1][D_W-1] ? REM_W'(-r_d[1]) : REM_W'(r_d[1]);
            default: dv_mag_nx = r_d[2][D_W-1] ? REM_W'(-r_d[2]) : REM_W'(r_d[2]);
        endcase
        vn_full  = shr_tz(r_acc + mul_prod, FRAC_BITS);
        kick_raw = shr_tz(mul_prod, FRAC_BITS);
        kick     = (kick_raw > C_KMAX) ? C_KMAX : kick_raw;
        hard_hit = impact > C_NMIN;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (item_fire) begin
                    n_state = i_item.op ? S_CLAMP : S_DONE;
                end
            end
            S_CLAMP: n_state = S_MUL;
            S_MUL: begin
                if (r_ph) begin
                    if (r_step == ST_RR) begin
                        if (r_dd >= mul_prod[DD_W-1:0]) begin
                            n_state = S_DONE;
                        end else if (r_dd != '0) begin
                            n_state = S_SQRT;
                        end
                    end else if (r_step == ST_VN_Z && !vn_full[P_W-1]) begin
                        n_state = S_DONE;
                    end else if (r_step == ST_KICK) begin
                        n_state = S_DONE;
                    end
                end else if (r_step == ST_KICK && !hard_hit) begin
                    n_state = S_DONE;
                end
            end
            S_SQRT: begin
                if (r_bit[0]) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (dv_last && r_ax == 2'd2) begin
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_DD_X;
            r_ph        <= 1'b0;
            r_radius    <= RADIUS_RST[U23_W-1:0];
            r_out_valid <= 1'b0;
            r_ground    <= 1'b0;
            r_bounced   <= 1'b0;
            r_peak      <= '0;
            r_squash    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Take a radius write
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
            end

            // Accept a transaction
            if (item_fire) begin
                if (!i_item.op) begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[i] <= in_a[i];
                        r_vel[i] <= in_b[i];
                    end
                    r_ground  <= 1'b0;
                    r_bounced <= 1'b0;
                    r_peak    <= '0;
                    r_squash  <= '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_c[i] <= in_a[i];
                        r_h[i] <= in_b[i];
                    end
                end
            end

            // Hold clamp results
            if (r_state == S_CLAMP) begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i]   <= cl_d[i];
                    r_dep[i] <= cl_dep[i];
                end
                r_pgt  <= cl_gt;
                r_step <= ST_DD_X;
                r_ph   <= 1'b0;
            end

            // Multiply steps: issue, then consume the product
            if (r_state == S_MUL) begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    // Skip the grip steps on a wall hit
                    r_step <= (r_step == ST_VEL_Z && !r_floor) ? ST_KICK : r_step + 5'd1;
                    case (r_step)
                        ST_DD_X: r_dd <= mul_prod[DD_W-1:0];
                        ST_DD_Y, ST_DD_Z: r_dd <= r_dd + mul_prod[DD_W-1:0];
                        ST_RR: begin
                            r_sx   <= r_dd;
                            r_root <= '0;
                            r_bit  <= DD_W'(1) << (DD_W - 2);
                            for (int i = 0; i < 3; i++) begin
                                if (in_ax == 2'(i)) begin
                                    r_n[i] <= r_pgt[i] ? C_ONE : -C_ONE;
                                end else begin
                                    r_n[i] <= '0;
                                end
                            end
                            r_pen <= signed'(MUL_W'(r_radius)) + MUL_W'(in_m);
                        end
                        ST_POS_X: r_pos[0] <= sat24(P_W'(r_pos[0]) + shr_tz(mul_prod, FRAC_BITS));
                        ST_POS_Y: r_pos[1] <= sat24(P_W'(r_pos[1]) + shr_tz(mul_prod, FRAC_BITS));
                        ST_POS_Z: r_pos[2] <= sat24(P_W'(r_pos[2]) + shr_tz(mul_prod, FRAC_BITS));
                        ST_VN_X:  r_acc <= mul_prod;
                        ST_VN_Y:  r_acc <= r_acc + mul_prod;
                        ST_VN_Z: begin
                            r_vn    <= MUL_W'(vn_full);
                            r_floor <= r_n[1] > C_NMIN;
                        end
                        ST_K:     r_k <= MUL_W'(shr_tz(mul_prod, FRAC_BITS));
                        ST_VEL_X: r_vel[0] <= sat24(P_W'(r_vel[0]) - shr_tz(mul_prod, FRAC_BITS));
                        ST_VEL_Y: r_vel[1] <= sat24(P_W'(r_vel[1]) - shr_tz(mul_prod, FRAC_BITS));
                        ST_VEL_Z: begin
                            r_vel[2] <= sat24(P_W'(r_vel[2]) - shr_tz(mul_prod, FRAC_BITS));
                            if (r_floor) begin
                                r_ground <= 1'b1;
                            end
                        end
                        ST_GRIP_X: r_vel[0] <= S24_W'(shr_tz(mul_prod, FRAC_BITS));
                        ST_GRIP_Z: r_vel[2] <= S24_W'(shr_tz(mul_prod, FRAC_BITS));
                        ST_KICK: begin
                            r_bounced <= 1'b1;
                            if (satu23(P_W'(impact)) > r_peak) begin
                                r_peak <= satu23(P_W'(impact));
                            end
                            r_squash <= satu23(P_W'(r_squash) + kick);
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
            end

            // Square root, one result bit per cycle
            if (r_state == S_SQRT) begin
                if (sub_ge) begin
                    r_sx <= sub_diff[DD_W-1:0];
                end
                r_root <= sq_root_nx;
                r_bit  <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_dl   <= sq_root_nx[S24_W-1:0];
                    r_pen  <= signed'(MUL_W'(r_radius)) - signed'(MUL_W'(sq_root_nx[S24_W-1:0]));
                    r_rem  <= dv_mag0[REM_W-1:0];
                    r_quo  <= '0;
                    r_qcnt <= '0;
                    r_ax   <= 2'd0;
                end
            end

            // Normal component by long division, one quotient bit per cycle
            if (r_state == S_DIV) begin
                if (dv_last) begin
                    r_n[r_ax] <= r_d[r_ax][D_W-1] ? -signed'(MUL_W'(dv_quo_nx))
                                                  : signed'(MUL_W'(dv_quo_nx));
                    r_ax   <= r_ax + 2'd1;
                    r_rem  <= dv_mag_nx;
                    r_quo  <= '0;
                    r_qcnt <= '0;
                    r_step <= ST_POS_X;
                    r_ph   <= 1'b0;
                end else begin
                    r_quo  <= dv_quo_nx;
                    r_rem  <= {dv_rem_nx[REM_W-2:0], 1'b0};
                    r_qcnt <= r_qcnt + QC_W'(1);
                end
            end

            // Load or drain the result register
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_o_pos[i] <= r_pos[i];
                    r_o_vel[i] <= r_vel[i];
                end
                r_o_ground  <= r_ground;
                r_o_bounced <= r_bounced;
                r_o_peak    <= r_peak;
                r_o_squash  <= r_squash;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.pos_x       = r_o_pos[0];
    assign o_result.pos_y       = r_o_pos[1];
    assign o_result.pos_z       = r_o_pos[2];
    assign o_result.vel_x       = r_o_vel[0];
    assign o_result.vel_y       = r_o_vel[1];
    assign o_result.vel_z       = r_o_vel[2];
    assign o_result.on_ground   = r_o_ground;
    assign o_result.bounced     = r_o_bounced;
    assign o_result.peak_impact = r_o_peak;
    assign o_result.squash_kick = r_o_squash;

    // Checks
    `SBC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, item_fire, r_state != S_IDLE, "idle after accept")
    `SBC_ASSERT_SAME(a_root_bit_onehot, i_clk, i_rst_n, r_state == S_SQRT, $onehot(r_bit), "root bit lost")
    `SBC_ASSERT_SAME(a_events_need_hit, i_clk, i_rst_n, r_peak != '0 || r_squash != '0, r_bounced, "impact without hit")

endmodule
